// ===== rtl/byte_stuffing_frame_decoder_assert.svh =====
// Assertion macros for the byte stuffing frame decoder.
`ifndef BYTE_STUFFING_FRAME_DECODER_ASSERT_SVH
`define BYTE_STUFFING_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BSFD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsfd assertion failed");

// Next-cycle implication, disabled during reset.
`define BSFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsfd assertion failed");

`endif

// ===== rtl/bsfd_pkg.sv =====
// Package with shared constants of the byte stuffing frame decoder.
package bsfd_pkg;
   localparam int FRAME_BYTES_DEF = 32;
   localparam int BYTE_W = 8;
   localparam int FLEN_W = 6;

   localparam logic [BYTE_W-1:0] FLAG_START = 8'h12;
   localparam logic [BYTE_W-1:0] FLAG_END   = 8'h13;
   localparam logic [BYTE_W-1:0] FLAG_ESC   = 8'h7D;
endpackage

// ===== rtl/bsfd_req_if.sv =====
// Request channel interface: one received stream byte per transaction.
interface bsfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/bsfd_rsp_if.sv =====
// Response channel interface: one decoded frame byte per transaction.
interface bsfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_last;
   logic       frame_empty;
   logic [5:0] frame_length;

   modport source (output valid, output frame_byte, output frame_last,
                   output frame_empty, output frame_length, input ready);
   modport sink (input valid, input frame_byte, input frame_last,
                 input frame_empty, input frame_length, output ready);
endinterface

// ===== rtl/bsfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bsfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/bsfd_fifo.sv =====
// Two-entry frame descriptor queue between front and back.
module bsfd_fifo #(
   parameter int WIDTH = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             not_empty,
   output logic             full
);
   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != 2'd0);
   assign full      = count_ff[1];
endmodule

// ===== rtl/bsfd_front.sv =====
// Front: accepts stream bytes, undoes the stuffing and fills a store bank.
module bsfd_front #(
   parameter int FRAME_BYTES = bsfd_pkg::FRAME_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   bsfd_req_if.sink req_ch,
   output logic push,
   output logic [$clog2(FRAME_BYTES+1):0] push_desc,
   input  logic rel_valid,
   input  logic rel_bank,
   output logic we,
   output logic [((FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1):0] waddr,
   output logic [bsfd_pkg::BYTE_W-1:0] wdata
);
   import bsfd_pkg::*;

   localparam int LEN_W = $clog2(FRAME_BYTES + 1);
   localparam int AW    = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

   localparam logic [1:0] MODE_WAIT = 2'd0;
   localparam logic [1:0] MODE_MSG  = 2'd1;
   localparam logic [1:0] MODE_ESC  = 2'd2;

   logic [1:0]       mode_ff, mode_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic             bank_ff, bank_in;
   logic [1:0]       busy_ff, busy_in;
   logic             acc;
   logic [7:0]       b;
   logic             room;
   logic             is_flag;

   assign req_ch.ready = !busy_ff[bank_ff];
   assign acc          = req_ch.valid && req_ch.ready;
   assign b            = req_ch.rx_byte;
   assign room         = (cnt_ff < LEN_W'(FRAME_BYTES));
   assign is_flag      = (b == FLAG_START) || (b == FLAG_END) || (b == FLAG_ESC);

   assign waddr     = {bank_ff, cnt_ff[AW-1:0]};
   assign wdata     = b;
   assign push_desc = {bank_ff, cnt_ff};

   always_comb begin
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      bank_in = bank_ff;
      push    = 1'b0;
      we      = 1'b0;
      if (acc) begin
         unique case (mode_ff)
            MODE_WAIT: begin
               if (b == FLAG_START) begin
                  cnt_in  = '0;
                  mode_in = MODE_MSG;
               end
            end
            MODE_MSG: begin
               if (b == FLAG_ESC) begin
                  mode_in = MODE_ESC;
               end else if (b == FLAG_END) begin
                  push    = 1'b1;
                  bank_in = !bank_ff;
                  cnt_in  = '0;
                  mode_in = MODE_WAIT;
               end else if (b == FLAG_START) begin
                  cnt_in  = '0;
                  mode_in = MODE_MSG;
               end else if (room) begin
                  we     = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  cnt_in  = '0;
                  mode_in = MODE_WAIT;
               end
            end
            MODE_ESC: begin
               if (is_flag && room) begin
                  we      = 1'b1;
                  cnt_in  = cnt_ff + 1'b1;
                  mode_in = MODE_MSG;
               end else begin
                  cnt_in  = '0;
                  mode_in = (b == FLAG_START) ? MODE_MSG : MODE_WAIT;
               end
            end
            default: begin
               cnt_in  = '0;
               mode_in = MODE_WAIT;
            end
         endcase
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (rel_valid) begin
         busy_in[rel_bank] = 1'b0;
      end
      if (push) begin
         busy_in[bank_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_WAIT;
         cnt_ff  <= '0;
         bank_ff <= 1'b0;
         busy_ff <= 2'b00;
      end else begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end
endmodule

// ===== rtl/bsfd_back.sv =====
// Back: drains completed frames from the store onto the response channel.
module bsfd_back #(
   parameter int FRAME_BYTES = bsfd_pkg::FRAME_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   bsfd_rsp_if.source rsp_ch,
   input  logic q_valid,
   input  logic [$clog2(FRAME_BYTES+1):0] q_head,
   output logic pop,
   output logic rel_valid,
   output logic rel_bank,
   output logic re,
   output logic [((FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1):0] raddr,
   input  logic [bsfd_pkg::BYTE_W-1:0] rdata
);
   import bsfd_pkg::*;

   localparam int LEN_W = $clog2(FRAME_BYTES + 1);
   localparam int AW    = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SHOW = 1'b1;

   logic             state_ff, state_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             empty_ff, empty_in;
   logic [LEN_W-1:0] len;
   logic             bank;
   logic [LEN_W-1:0] idx_nx;
   logic             last;
   logic             acc;

   assign len    = q_head[LEN_W-1:0];
   assign bank   = q_head[LEN_W];
   assign idx_nx = idx_ff + 1'b1;
   assign last   = empty_ff || (idx_nx == len);
   assign acc    = rsp_ch.valid && rsp_ch.ready;

   assign rsp_ch.valid        = (state_ff == ST_SHOW);
   assign rsp_ch.frame_byte   = empty_ff ? '0 : rdata;
   assign rsp_ch.frame_last   = last;
   assign rsp_ch.frame_empty  = empty_ff;
   assign rsp_ch.frame_length = FLEN_W'(len);

   assign rel_bank = bank;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      empty_in  = empty_ff;
      pop       = 1'b0;
      rel_valid = 1'b0;
      re        = 1'b0;
      raddr     = {bank, idx_nx[AW-1:0]};
      unique case (state_ff)
         ST_IDLE: begin
            raddr = {bank, {AW{1'b0}}};
            if (q_valid) begin
               state_in = ST_SHOW;
               idx_in   = '0;
               empty_in = (len == '0);
               re       = (len != '0);
            end
         end
         ST_SHOW: begin
            if (acc) begin
               if (last) begin
                  pop       = 1'b1;
                  rel_valid = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  re     = 1'b1;
                  idx_in = idx_nx;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         empty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         empty_ff <= empty_in;
      end
   end
endmodule

// ===== rtl/byte_stuffing_frame_decoder.sv =====
// Byte stuffing frame decoder top level.
//
// Takes one stuffed stream byte per cycle on req_ch and returns each completed
// frame on rsp_ch, one decoded byte per cycle while rsp_ch is ready, with the
// last byte marked; an empty frame returns a single transaction marked empty.
// The store holds two banks of FRAME_BYTES bytes: the front fills one bank
// while the back drains the other, and a two-entry descriptor queue sits
// between them. Between frames the back passes through its idle state, where
// it starts the read of the first byte of the frame at the head of the queue,
// before it shows that frame on rsp_ch.
// req_ch stalls only when the bank the front needs next still holds a frame
// that has not been fully delivered.
module byte_stuffing_frame_decoder #(
   parameter int FRAME_BYTES = bsfd_pkg::FRAME_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   bsfd_req_if.sink   req_ch,
   bsfd_rsp_if.source rsp_ch
);
   import bsfd_pkg::*;
   `include "byte_stuffing_frame_decoder_assert.svh"

   localparam int LEN_W = $clog2(FRAME_BYTES + 1);
   localparam int AW    = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

   logic             push;
   logic [LEN_W:0]   push_desc;
   logic [LEN_W:0]   q_head;
   logic             q_valid;
   logic             q_full;
   logic             pop;
   logic             rel_valid;
   logic             rel_bank;
   logic             we;
   logic [AW:0]      waddr;
   logic [BYTE_W-1:0] wdata;
   logic             re;
   logic [AW:0]      raddr;
   logic [BYTE_W-1:0] rdata;

   bsfd_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .push      (push),
      .push_desc (push_desc),
      .rel_valid (rel_valid),
      .rel_bank  (rel_bank),
      .we        (we),
      .waddr     (waddr),
      .wdata     (wdata)
   );

   bsfd_fifo #(.WIDTH(LEN_W + 1)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_desc),
      .pop       (pop),
      .head      (q_head),
      .not_empty (q_valid),
      .full      (q_full)
   );

   bsfd_ram #(.WIDTH(BYTE_W), .DEPTH(2 ** (AW + 1))) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   bsfd_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .rsp_ch    (rsp_ch),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .pop       (pop),
      .rel_valid (rel_valid),
      .rel_bank  (rel_bank),
      .re        (re),
      .raddr     (raddr),
      .rdata     (rdata)
   );

   `BSFD_ASSERT_NOW(a_no_push_full, clock, reset, push, !q_full)
   `BSFD_ASSERT_NOW(a_bank_split, clock, reset, we && re, waddr[AW] != raddr[AW])
   `BSFD_ASSERT_NOW(a_pop_nonempty, clock, reset, pop, q_valid)
   `BSFD_ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, q_valid)
endmodule

// ===== test/tb_byte_stuffing_frame_decoder.sv =====
// Testbench for the byte stuffing frame decoder: directed table, then random frames.
`timescale 1ns / 1ps

module tb_byte_stuffing_frame_decoder;
   import bsfd_pkg::*;

   localparam int HALF_PERIOD = 10;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int ITEMS_PER_PHASE = 110;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       empty;
      logic [5:0] length;
   } beat_type;

   typedef struct packed {
      logic [7:0] rx;
      logic       typed;
      beat_type   beat;
   } dir_row_type;

   typedef enum logic [1:0] {MODE_HUNT, MODE_BODY, MODE_ESCAPED} decode_mode_type;

   localparam beat_type EMPTY_BEAT = '{data: 8'h00, last: 1'b1, empty: 1'b1, length: 6'd0};
   localparam int NUM_ROWS = 25;

   localparam dir_row_type DIRECTED_ROWS[NUM_ROWS] = '{
      '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{FLAG_END, 1'b0, '0}, '{FLAG_ESC, 1'b0, '0},
      '{FLAG_START, 1'b0, '0}, '{FLAG_END, 1'b1, EMPTY_BEAT},
      '{FLAG_START, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0},
      '{FLAG_ESC, 1'b0, '0}, '{FLAG_START, 1'b0, '0},
      '{FLAG_ESC, 1'b0, '0}, '{FLAG_END, 1'b0, '0},
      '{FLAG_ESC, 1'b0, '0}, '{FLAG_ESC, 1'b0, '0}, '{FLAG_END, 1'b0, '0},
      '{FLAG_START, 1'b0, '0}, '{8'h41, 1'b0, '0}, '{FLAG_START, 1'b0, '0},
      '{FLAG_END, 1'b1, EMPTY_BEAT},
      '{FLAG_START, 1'b0, '0}, '{8'h55, 1'b0, '0}, '{FLAG_ESC, 1'b0, '0},
      '{8'h20, 1'b0, '0}, '{FLAG_END, 1'b0, '0}
   };

   logic clock;
   logic reset;

   bsfd_req_if req_ch ();
   bsfd_rsp_if rsp_ch ();

   byte_stuffing_frame_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   decode_mode_type decode_mode = MODE_HUNT;
   logic [7:0]      frame_buf[FRAME_BYTES_DEF];
   int              frame_fill = 0;
   beat_type        frame_beats[$];
   beat_type        pending_beats[$];
   int              decoded_items = 0;
   int              mismatches = 0;
   int              stall_cycles = 0;
   int              send_idle_pct = 27;
   int              recv_idle_pct = 69;
   logic            row_typed = 1'b0;
   beat_type        row_beat = '0;

   always #HALF_PERIOD clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   function automatic void store_payload(input logic [7:0] b);
      frame_buf[frame_fill] = b;
      frame_fill++;
      decode_mode = MODE_BODY;
   endfunction

   function automatic void drop_frame(input logic [7:0] b);
      frame_fill = 0;
      decode_mode = (b == FLAG_START) ? MODE_BODY : MODE_HUNT;
   endfunction

   // Advances the decoder state by one byte; completed frames land in frame_beats.
   function automatic void decode_byte(input logic [7:0] b);
      beat_type beat;
      frame_beats.delete();
      if (!(decode_mode == MODE_HUNT && b != FLAG_START))
         decoded_items++;
      case (decode_mode)
         MODE_HUNT: begin
            if (b == FLAG_START) begin
               frame_fill = 0;
               decode_mode = MODE_BODY;
            end
         end
         MODE_BODY: begin
            if (b == FLAG_ESC) begin
               decode_mode = MODE_ESCAPED;
            end else if (b == FLAG_END) begin
               if (frame_fill == 0) begin
                  frame_beats.push_back(EMPTY_BEAT);
               end else begin
                  for (int i = 0; i < frame_fill; i++) begin
                     beat.data = frame_buf[i];
                     beat.last = (i == frame_fill - 1);
                     beat.empty = 1'b0;
                     beat.length = frame_fill[5:0];
                     frame_beats.push_back(beat);
                  end
               end
               frame_fill = 0;
               decode_mode = MODE_HUNT;
            end else if (b == FLAG_START) begin
               frame_fill = 0;
            end else if (frame_fill < FRAME_BYTES_DEF) begin
               store_payload(b);
            end else begin
               drop_frame(b);
            end
         end
         MODE_ESCAPED: begin
            if ((b == FLAG_START || b == FLAG_END || b == FLAG_ESC) &&
                frame_fill < FRAME_BYTES_DEF)
               store_payload(b);
            else
               drop_frame(b);
         end
         default: begin
            frame_fill = 0;
            decode_mode = MODE_HUNT;
         end
      endcase
   endfunction

   // Check results first, then predict from the accepted byte.
   always @(posedge clock) begin
      beat_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_beats.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction, byte %02h",
                                         rsp_ch.frame_byte));
            end else begin
               want = pending_beats.pop_front();
               if (rsp_ch.frame_byte !== want.data)
                  report_mismatch($sformatf("frame_byte %02h, want %02h",
                                            rsp_ch.frame_byte, want.data));
               if (rsp_ch.frame_last !== want.last)
                  report_mismatch($sformatf("frame_last %b, want %b",
                                            rsp_ch.frame_last, want.last));
               if (rsp_ch.frame_empty !== want.empty)
                  report_mismatch($sformatf("frame_empty %b, want %b",
                                            rsp_ch.frame_empty, want.empty));
               if (rsp_ch.frame_length !== want.length)
                  report_mismatch($sformatf("frame_length %0d, want %0d",
                                            rsp_ch.frame_length, want.length));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            decode_byte(req_ch.rx_byte);
            if (row_typed)
               pending_beats.push_back(row_beat);
            else
               foreach (frame_beats[i]) pending_beats.push_back(frame_beats[i]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TIMEOUT: no transaction for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                            input beat_type tbeat = '0);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      row_typed = typed;
      row_beat = tbeat;
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic logic [7:0] rand_payload();
      logic [1:0] pick;
      pick = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 3) != 0)
         return 8'($urandom_range(0, 255));
      return (pick == 0) ? FLAG_START : (pick == 1) ? FLAG_END : FLAG_ESC;
   endfunction

   function automatic logic [7:0] rand_plain();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == FLAG_START || b == FLAG_END || b == FLAG_ESC);
      return b;
   endfunction

   task automatic send_payload(input logic [7:0] b);
      if (b == FLAG_START || b == FLAG_END || b == FLAG_ESC)
         send_byte(FLAG_ESC);
      send_byte(b);
   endtask

   task automatic random_stream(input int target);
      int first;
      int kind;
      int len;
      first = decoded_items;
      while (decoded_items - first < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, FRAME_BYTES_DEF)
                                              : $urandom_range(0, 10);
            send_byte(FLAG_START);
            repeat (len) send_payload(rand_payload());
            send_byte(FLAG_END);
         end else if (kind < 80) begin
            // overflow: the byte past a full store drops the frame
            send_byte(FLAG_START);
            repeat (FRAME_BYTES_DEF) send_payload(rand_payload());
            if ($urandom_range(0, 1))
               send_payload(FLAG_START);
            else
               send_payload(rand_payload());
            repeat ($urandom_range(0, 3)) send_payload(rand_payload());
            send_byte(FLAG_END);
         end else if (kind < 88) begin
            send_byte(FLAG_START);
            repeat ($urandom_range(0, 4)) send_payload(rand_payload());
         end else if (kind < 94) begin
            send_byte(FLAG_START);
            repeat ($urandom_range(0, 4)) send_payload(rand_payload());
            send_byte(FLAG_ESC);
            send_byte(rand_plain());
            if ($urandom_range(0, 1))
               send_byte(FLAG_END);
         end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.rx_byte = 8'h00;
      rsp_ch.ready = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++)
         send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].beat);

      random_stream(ITEMS_PER_PHASE);
      send_idle_pct = 69;
      recv_idle_pct = 27;
      random_stream(ITEMS_PER_PHASE);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_stream(ITEMS_PER_PHASE);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bsfd_pkg.sv
rtl/bsfd_req_if.sv
rtl/bsfd_rsp_if.sv
rtl/bsfd_ram.sv
rtl/bsfd_fifo.sv
rtl/bsfd_front.sv
rtl/bsfd_back.sv
rtl/byte_stuffing_frame_decoder.sv
test/tb_byte_stuffing_frame_decoder.sv
